>>> rtl/core/flow_cache_with_timeouts_unit_assert.svh
// ----------------------------------------------------------------------------
// Flow cache assertion macros
// Shared assertion wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef FLOW_CACHE_WITH_TIMEOUTS_UNIT_ASSERT_SVH
`define FLOW_CACHE_WITH_TIMEOUTS_UNIT_ASSERT_SVH

// Implication checked at every edge outside reset.
`define FCWT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("flow cache assertion failed");

// Condition that must never hold outside reset.
`define FCWT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("flow cache forbidden condition");

`endif

>>> rtl/core/fcwt_pkg.sv
// ----------------------------------------------------------------------------
// Flow cache package
// Types, constants and register codes shared by the flow cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fcwt_pkg;

  localparam int CACHE_SLOTS = 32;
  localparam int SlotW       = $clog2(CACHE_SLOTS);
  localparam int CntW        = $clog2(CACHE_SLOTS + 1);
  localparam int MaxResults  = 32;
  localparam int MsPerS      = 1000;
  localparam int AddrW       = 4;

  localparam logic [1:0] RegActive   = 2'd0;
  localparam logic [1:0] RegInactive = 2'd1;
  localparam logic [1:0] RegLimit    = 2'd2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [7:0]  tos;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] packet_bytes;
    logic [31:0] uptime_ms;
  } pkt_t;

  typedef struct packed {
    logic [31:0] rec_src_addr;
    logic [31:0] rec_dst_addr;
    logic [15:0] rec_src_port;
    logic [15:0] rec_dst_port;
    logic [7:0]  rec_protocol;
    logic [7:0]  rec_tos;
    logic [7:0]  rec_tcp_flags;
    logic [31:0] rec_packets;
    logic [31:0] rec_octets;
    logic [31:0] rec_first_ms;
    logic [31:0] rec_last_ms;
    logic        last_in_run;
  } rec_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [7:0]  tos;
    logic [7:0]  tcp_flags;
    logic [31:0] packets;
    logic [31:0] octets;
    logic [31:0] first_ms;
    logic [31:0] last_ms;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [31:0]     act_ms;
    logic [31:0]     inact_ms;
    logic [CntW-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             re;
    logic [SlotW-1:0] raddr;
    logic             we;
    logic [SlotW-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

  typedef struct packed {
    logic            busy;
    logic            pend_v;
    logic [CntW-1:0] occupancy;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRIME, ST_ACT, ST_INACT, ST_MATCH, ST_FIN, ST_EVICT, ST_INSERT,
    ST_DRAIN
  } state_e;

  function automatic rec_t entry_to_rec(entry_t e, logic last);
    rec_t r;
    r.rec_src_addr  = e.src_addr;
    r.rec_dst_addr  = e.dst_addr;
    r.rec_src_port  = e.src_port;
    r.rec_dst_port  = e.dst_port;
    r.rec_protocol  = e.protocol;
    r.rec_tos       = e.tos;
    r.rec_tcp_flags = e.tcp_flags;
    r.rec_packets   = e.packets;
    r.rec_octets    = e.octets;
    r.rec_first_ms  = e.first_ms;
    r.rec_last_ms   = e.last_ms;
    r.last_in_run   = last;
    return r;
  endfunction

endpackage

>>> rtl/core/fcwt_if.sv
// ----------------------------------------------------------------------------
// Flow cache channels
// Valid/ready channels for packet requests and exported flow records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fcwt_pkt_if;
  logic          valid;
  logic          ready;
  fcwt_pkg::pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fcwt_rec_if;
  logic          valid;
  logic          ready;
  fcwt_pkg::rec_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/fcwt_cfg_regs.sv
// ----------------------------------------------------------------------------
// Flow cache configuration registers
// APB register file; derives timeouts in ms and the clamped flow limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fcwt_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcwt_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output fcwt_pkg::cfg_t             cfg_o
);
  import fcwt_pkg::*;

  logic [15:0] act_q, inact_q;
  logic [5:0]  lim_q;
  logic        wr_en;
  logic [7:0]  lim_w;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 16'd60;
      inact_q <= 16'd10;
      lim_q   <= 6'd32;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegActive:   act_q   <= pwdata[15:0];
        RegInactive: inact_q <= pwdata[15:0];
        RegLimit:    lim_q   <= pwdata[5:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegActive:   prdata = {16'd0, act_q};
      RegInactive: prdata = {16'd0, inact_q};
      RegLimit:    prdata = {26'd0, lim_q};
      default:     prdata = 32'd0;
    endcase
  end

  // clamp limit into 1..CACHE_SLOTS
  always_comb begin
    lim_w = {2'b00, lim_q};
    if (lim_w == 8'd0) lim_w = 8'd1;
    if (lim_w > 8'(CACHE_SLOTS)) lim_w = 8'(CACHE_SLOTS);
    cfg_o.act_ms   = 32'(act_q) * 32'(MsPerS);
    cfg_o.inact_ms = 32'(inact_q) * 32'(MsPerS);
    cfg_o.limit    = CntW'(lim_w);
  end

endmodule

>>> rtl/core/fcwt_slot_ram.sv
// ----------------------------------------------------------------------------
// Flow cache slot memory
// One write port, one registered read port; read data holds without a read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fcwt_slot_ram #(
  parameter int Depth = 32,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/fcwt_ctrl.sv
// ----------------------------------------------------------------------------
// Flow cache sequencer
// Scans slots for timeouts, lookup and eviction; buffers records for export.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fcwt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcwt_pkg::cfg_t     cfg_i,
  fcwt_pkt_if.sink           pkt_i,
  fcwt_rec_if.source         rec_o,
  output fcwt_pkg::mem_req_t mem_o,
  input  fcwt_pkg::entry_t   rdata_i,
  output fcwt_pkg::stat_t    stat_o
);
  import fcwt_pkg::*;

  state_e state_q, state_d;
  logic [CACHE_SLOTS-1:0] valid_q, valid_d;
  logic [SlotW-1:0] idx_q, idx_d, nxt_idx, free_idx, hit_idx_q, hit_idx_d, old_idx_q, old_idx_d;
  logic hit_f_q, hit_f_d, old_f_q, old_f_d, free_f;
  entry_t hit_q, hit_d, old_q, old_d, pend_q, pend_d, upd, ins;
  logic pend_v_q, pend_v_d;
  rec_t out_q, out_d;
  logic out_v_q, out_v_d, out_free;
  pkt_t pkt_q, pkt_d;
  logic [CntW-1:0] n_q, n_d, occ;
  logic last_slot, cur_v, expired, key_eq, room;
  logic emit, stall;
  entry_t emit_e;
  logic [31:0] stamp, tmo, age;

  assign pkt_i.ready = (state_q == ST_IDLE);
  assign rec_o.valid = out_v_q;
  assign rec_o.data  = out_q;
  assign out_free    = !out_v_q || rec_o.ready;
  assign occ         = CntW'($countones(valid_q));
  assign last_slot   = (idx_q == SlotW'(CACHE_SLOTS - 1));
  assign nxt_idx     = last_slot ? '0 : idx_q + 1'b1;
  assign cur_v       = valid_q[idx_q];
  assign stamp       = (state_q == ST_ACT) ? rdata_i.first_ms : rdata_i.last_ms;
  assign tmo         = (state_q == ST_ACT) ? cfg_i.act_ms : cfg_i.inact_ms;
  assign age         = pkt_q.uptime_ms - stamp;
  assign expired     = cur_v && (age > tmo);
  assign room        = (32'(n_q) < MaxResults);
  assign key_eq      = (rdata_i.src_addr == pkt_q.src_addr) &&
                       (rdata_i.dst_addr == pkt_q.dst_addr) &&
                       (rdata_i.src_port == pkt_q.src_port) &&
                       (rdata_i.dst_port == pkt_q.dst_port) &&
                       (rdata_i.protocol == pkt_q.protocol);

  // lowest free slot
  always_comb begin
    free_f   = 1'b0;
    free_idx = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_f   = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  always_comb begin
    upd           = hit_q;
    upd.packets   = hit_q.packets + 32'd1;
    upd.octets    = hit_q.octets + 32'(pkt_q.packet_bytes);
    upd.tcp_flags = hit_q.tcp_flags | pkt_q.tcp_flag_bits;
    upd.last_ms   = pkt_q.uptime_ms;
    ins.src_addr  = pkt_q.src_addr;
    ins.dst_addr  = pkt_q.dst_addr;
    ins.src_port  = pkt_q.src_port;
    ins.dst_port  = pkt_q.dst_port;
    ins.protocol  = pkt_q.protocol;
    ins.tos       = pkt_q.tos;
    ins.tcp_flags = pkt_q.tcp_flag_bits;
    ins.packets   = 32'd1;
    ins.octets    = 32'(pkt_q.packet_bytes);
    ins.first_ms  = pkt_q.uptime_ms;
    ins.last_ms   = pkt_q.uptime_ms;
  end

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    idx_d     = idx_q;
    hit_f_d   = hit_f_q;
    hit_idx_d = hit_idx_q;
    hit_d     = hit_q;
    old_f_d   = old_f_q;
    old_idx_d = old_idx_q;
    old_d     = old_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q && !rec_o.ready;
    pkt_d     = pkt_q;
    n_d       = n_q;
    mem_o     = '0;
    emit      = 1'b0;
    emit_e    = rdata_i;

    case (state_q)
      ST_IDLE: begin
        if (pkt_i.valid) begin
          pkt_d   = pkt_i.data;
          n_d     = '0;
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = '0;
        idx_d       = '0;
        hit_f_d     = 1'b0;
        old_f_d     = 1'b0;
        state_d     = ST_ACT;
      end
      ST_ACT, ST_INACT: begin
        emit = expired && room;
      end
      ST_EVICT: begin
        emit   = room;
        emit_e = old_q;
      end
      default: ;
    endcase

    // hold the sequencer while the pending record cannot move on
    stall = emit && pend_v_q && !out_free;

    if (emit && !stall) begin
      if (pend_v_q) begin
        out_d   = entry_to_rec(pend_q, 1'b0);
        out_v_d = 1'b1;
      end
      pend_d   = emit_e;
      pend_v_d = 1'b1;
      n_d      = n_q + 1'b1;
    end

    case (state_q)
      ST_ACT, ST_INACT, ST_MATCH: begin
        if (!stall) begin
          if (state_q != ST_MATCH && expired) valid_d[idx_q] = 1'b0;
          if (state_q == ST_MATCH && cur_v) begin
            if (!hit_f_q && key_eq) begin
              hit_f_d   = 1'b1;
              hit_idx_d = idx_q;
              hit_d     = rdata_i;
            end
            if (!old_f_q || (rdata_i.last_ms < old_q.last_ms)) begin
              old_f_d   = 1'b1;
              old_idx_d = idx_q;
              old_d     = rdata_i;
            end
          end
          mem_o.re    = 1'b1;
          mem_o.raddr = nxt_idx;
          idx_d       = nxt_idx;
          if (last_slot) begin
            case (state_q)
              ST_ACT:   state_d = ST_INACT;
              ST_INACT: state_d = ST_MATCH;
              default:  state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_FIN: begin
        if (hit_f_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = hit_idx_q;
          mem_o.wdata = upd;
          state_d     = ST_DRAIN;
        end else if (occ >= cfg_i.limit && old_f_q) begin
          state_d = ST_EVICT;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_EVICT: begin
        if (!stall) begin
          valid_d[old_idx_q] = 1'b0;
          state_d            = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (free_f) begin
          mem_o.we          = 1'b1;
          mem_o.waddr       = free_idx;
          mem_o.wdata       = ins;
          valid_d[free_idx] = 1'b1;
        end
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d    = entry_to_rec(pend_q, 1'b1);
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      hit_f_q  <= 1'b0;
      old_f_q  <= 1'b0;
      idx_q    <= '0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      hit_f_q  <= hit_f_d;
      old_f_q  <= old_f_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    hit_q     <= hit_d;
    old_idx_q <= old_idx_d;
    old_q     <= old_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
    pkt_q     <= pkt_d;
  end

  assign stat_o.busy      = (state_q != ST_IDLE);
  assign stat_o.pend_v    = pend_v_q;
  assign stat_o.occupancy = occ;

endmodule

>>> rtl/core/flow_cache_with_timeouts_unit.sv
// ----------------------------------------------------------------------------
// Flow cache with timeouts
// Flow table with active/inactive timeout export and oldest-flow eviction.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  pkt_i    | in  | valid/ready      | packet key, tos, flags, size, uptime
//  rec_o    | out | valid/ready      | exported flow record, last_in_run
//  apb      | in  | psel/penable     | timeouts and flow limit registers
//
// From one accepted request to the next a packet goes through accept, prime,
// three scans of the slot memory (active timeout, inactive timeout, lookup
// with oldest search), one slot per cycle on its single read port, then
// finish, evict and insert on a miss (evict only at the flow limit) and drain.
// A stalled record output holds the scan at the slot that exports.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flow_cache_with_timeouts_unit_assert.svh"
module flow_cache_with_timeouts_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fcwt_pkt_if.sink                   pkt_i,
  fcwt_rec_if.source                 rec_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcwt_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import fcwt_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  entry_t   rdata;
  stat_t    stat;

  // register file: timeouts scaled to ms, limit clamped
  fcwt_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // slot store: one flow record per entry
  fcwt_slot_ram #(.Depth(CACHE_SLOTS), .Width(EntryW)) u_ram (
    .clk_i,
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(rdata)
  );

  // sequencer: scan, match, evict, insert, export
  fcwt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .cfg_i  (cfg),
    .pkt_i  (pkt_i),
    .rec_o  (rec_o),
    .mem_o  (mem_req),
    .rdata_i(rdata),
    .stat_o (stat)
  );

  // one packet at a time: ready drops right after an accept
  `FCWT_ASSERT(a_one_pkt, clk_i, rst_ni, (pkt_i.valid && pkt_i.ready) |=> !pkt_i.ready)
  // no record left behind when the next packet may enter
  `FCWT_NEVER(a_no_pend_idle, clk_i, rst_ni, pkt_i.ready && stat.pend_v)
  // never take a request while a packet is in flight
  `FCWT_NEVER(a_busy_ready, clk_i, rst_ni, pkt_i.ready && stat.busy)
  // occupancy never exceeds the slot count
  `FCWT_NEVER(a_occ, clk_i, rst_ni, 32'(stat.occupancy) > CACHE_SLOTS)

endmodule

>>> bench/flow_cache_with_timeouts_unit_test.sv
// ----------------------------------------------------------------------------
// Flow cache testbench
// Drives packet requests with bursts and gaps, stalls the record output and
// checks every exported flow record against a cycle-free flow table model.
// Registers are written over APB between phases while the cache is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module flow_cache_with_timeouts_unit_test;
  import fcwt_pkg::*;

  localparam int PktLatency  = 3 * CACHE_SLOTS + 6;
  localparam int IdleLimit   = 20000;
  localparam int RandomPkts  = 180;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fcwt_pkt_if pkt_ch ();
  fcwt_rec_if rec_ch ();

  flow_cache_with_timeouts_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pkt_i   (pkt_ch.sink),
    .rec_o   (rec_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Model of the flow table: registers, slots and the records owed.
  logic [15:0] act_s, inact_s;
  logic [5:0]  limit_reg;
  logic        flow_live [CACHE_SLOTS];
  entry_t      flow_tab [CACHE_SLOTS];
  rec_t        owed_recs [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          stall_mode = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic rec_t entry_to_rec_tb(input entry_t e);
    rec_t r;
    r = {e.src_addr, e.dst_addr, e.src_port, e.dst_port, e.protocol, e.tos,
         e.tcp_flags, e.packets, e.octets, e.first_ms, e.last_ms, 1'b0};
    return r;
  endfunction

  function automatic void export_flow(input int s, ref int n);
    if (n < MaxResults) begin
      owed_recs.push_back(entry_to_rec_tb(flow_tab[s]));
      n++;
    end
    flow_live[s] = 1'b0;
  endfunction

  // Work out the records one packet exports and update the table.
  function automatic void predict_packet(input pkt_t p);
    logic [31:0] act_ms, inact_ms;
    int n, hit, count, lim, oldest, free_s;
    act_ms   = act_s * 32'd1000;
    inact_ms = inact_s * 32'd1000;
    n = 0; hit = -1; count = 0; oldest = -1; free_s = -1;
    lim = (limit_reg < 1) ? 1 : (limit_reg > CACHE_SLOTS ? CACHE_SLOTS : limit_reg);
    for (int s = 0; s < CACHE_SLOTS; s++)
      if (flow_live[s] && (p.uptime_ms - flow_tab[s].first_ms) > act_ms)
        export_flow(s, n);
    for (int s = 0; s < CACHE_SLOTS; s++)
      if (flow_live[s] && (p.uptime_ms - flow_tab[s].last_ms) > inact_ms)
        export_flow(s, n);
    for (int s = 0; s < CACHE_SLOTS; s++) begin
      if (!flow_live[s]) continue;
      count++;
      if (hit < 0 && flow_tab[s].src_addr == p.src_addr &&
          flow_tab[s].dst_addr == p.dst_addr && flow_tab[s].src_port == p.src_port &&
          flow_tab[s].dst_port == p.dst_port && flow_tab[s].protocol == p.protocol)
        hit = s;
    end
    if (hit >= 0) begin
      flow_tab[hit].packets   += 1;
      flow_tab[hit].octets    += p.packet_bytes;
      flow_tab[hit].tcp_flags |= p.tcp_flag_bits;
      flow_tab[hit].last_ms    = p.uptime_ms;
    end else begin
      if (count >= lim) begin
        for (int s = 0; s < CACHE_SLOTS; s++)
          if (flow_live[s] && (oldest < 0 ||
              flow_tab[s].last_ms < flow_tab[oldest].last_ms))
            oldest = s;
        if (oldest >= 0) export_flow(oldest, n);
      end
      for (int s = 0; s < CACHE_SLOTS && free_s < 0; s++)
        if (!flow_live[s]) free_s = s;
      if (free_s >= 0) begin
        flow_live[free_s] = 1'b1;
        flow_tab[free_s] = {p.src_addr, p.dst_addr, p.src_port, p.dst_port,
                            p.protocol, p.tos, p.tcp_flag_bits, 32'd1,
                            32'(p.packet_bytes), p.uptime_ms, p.uptime_ms};
      end
    end
    if (n > 0) owed_recs[$].last_in_run = 1'b1;
  endfunction

  // Record checker: compare each accepted record with the oldest owed one.
  always @(posedge clk_i) begin
    rec_t got, want;
    if (rst_ni && rec_ch.valid && rec_ch.ready) begin
      got = rec_ch.data;
      if (owed_recs.size() == 0) begin
        report_mismatch("unexpected record src", got.rec_src_addr, 32'h0);
      end else begin
        want = owed_recs.pop_front();
        if (got.rec_src_addr != want.rec_src_addr)
          report_mismatch("src_addr", got.rec_src_addr, want.rec_src_addr);
        if (got.rec_dst_addr != want.rec_dst_addr)
          report_mismatch("dst_addr", got.rec_dst_addr, want.rec_dst_addr);
        if (got.rec_src_port != want.rec_src_port)
          report_mismatch("src_port", got.rec_src_port, want.rec_src_port);
        if (got.rec_dst_port != want.rec_dst_port)
          report_mismatch("dst_port", got.rec_dst_port, want.rec_dst_port);
        if (got.rec_protocol != want.rec_protocol)
          report_mismatch("protocol", got.rec_protocol, want.rec_protocol);
        if (got.rec_tos != want.rec_tos)
          report_mismatch("tos", got.rec_tos, want.rec_tos);
        if (got.rec_tcp_flags != want.rec_tcp_flags)
          report_mismatch("tcp_flags", got.rec_tcp_flags, want.rec_tcp_flags);
        if (got.rec_packets != want.rec_packets)
          report_mismatch("packets", got.rec_packets, want.rec_packets);
        if (got.rec_octets != want.rec_octets)
          report_mismatch("octets", got.rec_octets, want.rec_octets);
        if (got.rec_first_ms != want.rec_first_ms)
          report_mismatch("first_ms", got.rec_first_ms, want.rec_first_ms);
        if (got.rec_last_ms != want.rec_last_ms)
          report_mismatch("last_ms", got.rec_last_ms, want.rec_last_ms);
        if (got.last_in_run != want.last_in_run)
          report_mismatch("last_in_run", got.last_in_run, want.last_in_run);
      end
    end
  end

  // Receiver stall pattern: alternate between free-running and choppy stretches.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    if (!stall_mode) rec_ch.ready <= 1'b1;
    else rec_ch.ready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((pkt_ch.valid && pkt_ch.ready) || (rec_ch.valid && rec_ch.ready))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // APB write: setup then access; pready is always high.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegActive:   act_s     = val[15:0];
      RegInactive: inact_s   = val[15:0];
      default:     limit_reg = val[5:0];
    endcase
  endtask

  // Hold until every owed record has come, then let the scan settle.
  task automatic drain_records();
    while (owed_recs.size() != 0) @(posedge clk_i);
    repeat (PktLatency + 8) @(posedge clk_i);
  endtask

  // Send one packet request; predict on acceptance.
  task automatic send_packet(input pkt_t p);
    pkt_ch.valid <= 1'b1;
    pkt_ch.data  <= p;
    @(posedge clk_i);
    while (!pkt_ch.ready) @(posedge clk_i);
    predict_packet(p);
  endtask

  task automatic send_gap();
    pkt_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  // Directed rows; expected records come from the model of the table.
  typedef struct {
    pkt_t pkt;
  } step_row_t;

  function automatic pkt_t mk(input logic [31:0] sa, input logic [15:0] sp,
                              input logic [7:0] pr, input logic [7:0] fl,
                              input logic [15:0] b, input logic [31:0] t);
    pkt_t p;
    p = {sa, ~sa, sp, ~sp, pr, 8'hA5 ^ fl, fl, b, t};
    return p;
  endfunction

  // Random packet from a small pool of flows so hits and timeouts happen.
  logic [31:0] clock_ms;
  function automatic pkt_t rand_packet();
    pkt_t p;
    int f;
    f = $urandom_range(0, 11);
    if ($urandom_range(0, 9) == 0) begin
      p = {$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom), 16'($urandom), $urandom};
    end else begin
      clock_ms += $urandom_range(0, 4000);
      p = {32'h0A000000 + f, 32'hFFFF0000 | f, 16'(f * 257), 16'(16'hFFFF - f),
           8'(f[0] ? 6 : 17), 8'($urandom), 8'($urandom), 16'($urandom), clock_ms};
    end
    return p;
  endfunction

  step_row_t dir_rows [$];
  pkt_t      cur;

  initial begin
    pkt_ch.valid = 1'b0;
    pkt_ch.data  = '0;
    act_s = 16'd60; inact_s = 16'd10; limit_reg = 6'd32;
    for (int s = 0; s < CACHE_SLOTS; s++) begin
      flow_live[s] = 1'b0;
      flow_tab[s]  = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: insert, hit, extremes, ties, timeouts.
    dir_rows.push_back('{mk(32'h0, 16'h0, 8'h0, 8'h00, 16'h0, 32'd0)});
    dir_rows.push_back('{mk(32'h0, 16'h0, 8'h0, 8'hFF, 16'hFFFF, 32'd0)});
    dir_rows.push_back('{mk(32'hFFFFFFFF, 16'hFFFF, 8'hFF, 8'h12, 16'hFFFF, 32'd0)});
    dir_rows.push_back('{mk(32'h1, 16'h1, 8'd6, 8'h02, 16'd60, 32'd500)});
    dir_rows.push_back('{mk(32'h1, 16'h1, 8'd6, 8'h10, 16'd40, 32'd9000)});
    // idle longer than the inactive timeout exports the older flows
    dir_rows.push_back('{mk(32'h2, 16'h2, 8'd17, 8'h00, 16'd100, 32'd10001)});
    // past the active timeout for everything
    dir_rows.push_back('{mk(32'h3, 16'h3, 8'd17, 8'h00, 16'd1, 32'd70002)});
    // time wraps around zero
    dir_rows.push_back('{mk(32'h4, 16'h4, 8'd1, 8'h00, 16'd1, 32'hFFFFFFFF)});
    dir_rows.push_back('{mk(32'h5, 16'h5, 8'd1, 8'h00, 16'd1, 32'd3000)});
    foreach (dir_rows[i]) send_packet(dir_rows[i].pkt);
    pkt_ch.valid <= 1'b0;
    drain_records();

    // Small flow limit and huge timeouts: eviction of the oldest, ties to lowest slot.
    write_reg(RegActive, 32'hFFFF);
    write_reg(RegInactive, 32'hFFFF);
    write_reg(RegLimit, 32'd2);
    for (int i = 0; i < 6; i++)
      send_packet(mk(32'h100 + i, 16'd7, 8'd6, 8'(1 << i), 16'd10, 32'd20000 + (i / 2)));
    pkt_ch.valid <= 1'b0;
    drain_records();
    // Zero limit behaves like one; zero timeouts export anything older than now.
    write_reg(RegLimit, 32'd0);
    write_reg(RegActive, 32'd0);
    write_reg(RegInactive, 32'd0);
    for (int i = 0; i < 4; i++)
      send_packet(mk(32'h200 + i, 16'd9, 8'd17, 8'h00, 16'd5, 32'd30000 + i));
    pkt_ch.valid <= 1'b0;
    drain_records();

    // Random phases over several register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(RegActive, 32'd60); write_reg(RegInactive, 32'd10);
                 write_reg(RegLimit, 32'd32); end
        1: begin write_reg(RegActive, 32'd20); write_reg(RegInactive, 32'd5);
                 write_reg(RegLimit, 32'd4); end
        2: begin write_reg(RegActive, 32'd65535); write_reg(RegInactive, 32'd65535);
                 write_reg(RegLimit, 32'd63); end
        default: begin write_reg(RegActive, 32'd8); write_reg(RegInactive, 32'd3);
                 write_reg(RegLimit, 32'd1); end
      endcase
      clock_ms = 32'd100000 * (ph + 1);
      for (int k = 0; k < RandomPkts / 4; k++) begin
        cur = rand_packet();
        send_packet(cur);
        if ($urandom_range(0, 3) == 0) send_gap();
        // Hold off once per phase until everything owed has come.
        if (k == 20) begin
          pkt_ch.valid <= 1'b0;
          while (owed_recs.size() != 0) @(posedge clk_i);
        end
      end
      pkt_ch.valid <= 1'b0;
      drain_records();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/fcwt_pkg.sv
rtl/core/fcwt_if.sv
rtl/core/fcwt_cfg_regs.sv
rtl/core/fcwt_slot_ram.sv
rtl/core/fcwt_ctrl.sv
rtl/core/flow_cache_with_timeouts_unit.sv
bench/flow_cache_with_timeouts_unit_test.sv
